// ----- hdl/lrgsf_pkg.sv -----
// Shared types and constants for the lidar range gate and spike filter.
// No dependencies; imported by every module of the block.
package lrgsf_pkg;

    localparam int RANGE_W  = 16;
    localparam int FACTOR_W = 12;
    localparam int SKIP_W   = 8;
    localparam int SLEN_W   = 13;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;

    localparam logic [RANGE_W-1:0] NO_RETURN = 16'hFFFF;

    // register indexes on the configuration port
    localparam logic [CFG_AW-1:0] CFG_GATE_ENABLE  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_RANGE_MIN    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_RANGE_MAX    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_SPIKE_ENABLE = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_EDGE_SKIP    = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_SPIKE_FACTOR = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_SCAN_LENGTH  = 3'd6;

    typedef struct packed {
        logic                gate_enable;
        logic [RANGE_W-1:0]  range_min;
        logic [RANGE_W-1:0]  range_max;
        logic                spike_enable;
        logic [SKIP_W-1:0]   edge_skip;
        logic [FACTOR_W-1:0] spike_factor;
        logic [SLEN_W-1:0]   scan_length;
    } cfg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] mm;
        logic               last;
    } item_t;

    // up to two result items produced by one input item
    typedef struct packed {
        logic [1:0] cnt;
        item_t      item0;
        item_t      item1;
    } push_t;

endpackage

// ----- hdl/lrgsf_gate.sv -----
// Input stage: range window gate and input register.
// Depends on lrgsf_pkg.
module lrgsf_gate (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lrgsf_pkg::cfg_t              cfg,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [lrgsf_pkg::RANGE_W-1:0] s_range_mm,
    input  logic                         take,
    output logic                         st_valid,
    output logic [lrgsf_pkg::RANGE_W-1:0] st_gated
);
    import lrgsf_pkg::*;

    logic               valid_reg, valid_next;
    logic [RANGE_W-1:0] data_reg, data_next;
    logic               in_fire;
    logic [RANGE_W-1:0] gated;

    always_comb begin
        gated = s_range_mm;
        if (cfg.gate_enable && (s_range_mm > cfg.range_max || s_range_mm < cfg.range_min)) begin
            gated = NO_RETURN;
        end
    end

    assign s_ready = !valid_reg || take;
    assign in_fire = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_fire) begin
            valid_next = 1'b1;
            data_next  = gated;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign st_valid = valid_reg;
    assign st_gated = data_reg;

endmodule

// ----- hdl/lrgsf_spike.sv -----
// Scan state and spike decision; emits zero, one or two result items per item.
// Depends on lrgsf_pkg.
module lrgsf_spike #(
    parameter int MAX_SCAN = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lrgsf_pkg::cfg_t              cfg,
    input  logic                         fire,
    input  logic [lrgsf_pkg::RANGE_W-1:0] g,
    output lrgsf_pkg::push_t             push,
    output logic                         pend_valid
);
    import lrgsf_pkg::*;

    localparam int LEN_W  = $clog2(MAX_SCAN + 1);
    localparam int CW     = (LEN_W > SKIP_W ? LEN_W : SKIP_W) + 1;
    localparam int PROD_W = RANGE_W + FACTOR_W;

    logic [RANGE_W-1:0] left_reg, left_next;
    logic [RANGE_W-1:0] pend_reg, pend_next;
    logic               pvalid_reg, pvalid_next;
    logic [LEN_W-1:0]   idx_reg, idx_next;

    logic [31:0]        sl_ext, len_full;
    logic [CW-1:0]      len_w, skip_w, p_w, idx_w;
    logic [SKIP_W-1:0]  skip;
    logic [PROD_W-1:0]  prod, left_sh, g_sh;
    logic               below_left, below_right, spike, scan_done;
    logic [RANGE_W-1:0] v;

    always_comb begin
        sl_ext = 32'(cfg.scan_length);
        if (sl_ext < 32'd2) begin
            len_full = 32'd2;
        end else if (sl_ext > 32'(MAX_SCAN)) begin
            len_full = 32'(MAX_SCAN);
        end else begin
            len_full = sl_ext;
        end
    end

    assign skip   = (cfg.edge_skip == '0) ? SKIP_W'(1) : cfg.edge_skip;
    assign len_w  = CW'(len_full[LEN_W-1:0]);
    assign skip_w = CW'(skip);
    assign idx_w  = CW'(idx_reg);
    assign p_w    = idx_w - CW'(1);

    // value * factor (Q4.8) against neighbor * 256, exact
    assign prod    = PROD_W'(pend_reg) * PROD_W'(cfg.spike_factor);
    assign left_sh = PROD_W'({left_reg, 8'h00});
    assign g_sh    = PROD_W'({g, 8'h00});

    assign below_left  = (left_reg == NO_RETURN) || (prod < left_sh);
    assign below_right = (g == NO_RETURN) || (prod < g_sh);

    assign spike = cfg.spike_enable && (pend_reg != NO_RETURN) && (p_w >= skip_w)
                   && ((p_w + skip_w) < len_w) && below_left && below_right;
    assign v         = spike ? NO_RETURN : pend_reg;
    assign scan_done = (idx_w + CW'(1)) >= len_w;

    always_comb begin
        left_next   = left_reg;
        pend_next   = pend_reg;
        pvalid_next = pvalid_reg;
        idx_next    = idx_reg;
        push.cnt        = 2'd0;
        push.item0.mm   = v;
        push.item0.last = 1'b0;
        push.item1.mm   = g;
        push.item1.last = 1'b1;
        if (fire) begin
            if (!pvalid_reg) begin
                // first item of a scan only primes the pending sample
                pend_next   = g;
                pvalid_next = 1'b1;
                idx_next    = LEN_W'(1);
            end else if (scan_done) begin
                push.cnt    = 2'd2;
                left_next   = NO_RETURN;
                pend_next   = NO_RETURN;
                pvalid_next = 1'b0;
                idx_next    = '0;
            end else begin
                push.cnt  = 2'd1;
                left_next = v;
                pend_next = g;
                idx_next  = idx_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= NO_RETURN;
            pend_reg   <= NO_RETURN;
            pvalid_reg <= 1'b0;
            idx_reg    <= '0;
        end else begin
            left_reg   <= left_next;
            pend_reg   <= pend_next;
            pvalid_reg <= pvalid_next;
            idx_reg    <= idx_next;
        end
    end

    assign pend_valid = pvalid_reg;

endmodule

// ----- hdl/lrgsf_outq.sv -----
// Three-entry result queue; takes up to two items per cycle, hands out one.
// Depends on lrgsf_pkg.
module lrgsf_outq (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lrgsf_pkg::push_t             push,
    output logic [1:0]                   count,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [lrgsf_pkg::RANGE_W-1:0] m_filtered_mm,
    output logic                         m_scan_end
);
    import lrgsf_pkg::*;

    localparam int DEPTH = 3;

    item_t      mem_reg [DEPTH];
    logic [1:0] wr_reg, wr_next, rd_reg, rd_next, cnt_reg, cnt_next;
    logic [1:0] wr_plus1;
    logic       pop;

    function automatic logic [1:0] wrap_inc(input logic [1:0] ptr);
        return (ptr == 2'(DEPTH - 1)) ? 2'd0 : ptr + 2'd1;
    endfunction

    assign wr_plus1 = wrap_inc(wr_reg);
    assign m_valid  = cnt_reg != 2'd0;
    assign pop      = m_valid && m_ready;

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = pop ? wrap_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + push.cnt - {1'b0, pop};
        case (push.cnt)
            2'd1:    wr_next = wr_plus1;
            2'd2:    wr_next = wrap_inc(wr_plus1);
            default: wr_next = wr_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push.cnt != 2'd0) begin
            mem_reg[wr_reg] <= push.item0;
        end
        if (push.cnt == 2'd2) begin
            mem_reg[wr_plus1] <= push.item1;
        end
    end

    assign count         = cnt_reg;
    assign m_filtered_mm = mem_reg[rd_reg].mm;
    assign m_scan_end    = mem_reg[rd_reg].last;

endmodule

// ----- hdl/lidar_range_gate_spike_filter.sv -----
// Top level of the lidar range gate and spike filter: config registers and stages.
// Depends on lrgsf_pkg, lrgsf_gate, lrgsf_spike and lrgsf_outq.
//
//  port group   direction  handshake          payload
//  s_           in         s_valid/s_ready    s_range_mm
//  m_           out        m_valid/m_ready    m_filtered_mm, m_scan_end
//  cfg_         in         cfg_we             cfg_index, cfg_wdata
//
// One item per cycle sustained while m_ready is high, but for the scan end stall. An
// item is registered in the gate register and decided when its right neighbor is taken;
// its result is then written into a three-entry queue and offered on m_ from there.
// The last item of a scan yields two results and stalls input until the queue has room.
// Reset (synchronous, aresetn low) restores register defaults and empties the scan.
// Stalls on m_ready back up through the queue into s_ready.
module lidar_range_gate_spike_filter #(
    parameter int MAX_SCAN = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [lrgsf_pkg::RANGE_W-1:0] s_range_mm,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [lrgsf_pkg::RANGE_W-1:0] m_filtered_mm,
    output logic                         m_scan_end,
    input  logic                         cfg_we,
    input  logic [lrgsf_pkg::CFG_AW-1:0] cfg_index,
    input  logic [lrgsf_pkg::CFG_DW-1:0] cfg_wdata
);
    import lrgsf_pkg::*;

    cfg_t               cfg_reg, cfg_next;
    logic               st_valid, take, pend_valid;
    logic [RANGE_W-1:0] st_gated;
    push_t              push;
    logic [1:0]         q_count;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_GATE_ENABLE:  cfg_next.gate_enable  = cfg_wdata[0];
                CFG_RANGE_MIN:    cfg_next.range_min    = cfg_wdata;
                CFG_RANGE_MAX:    cfg_next.range_max    = cfg_wdata;
                CFG_SPIKE_ENABLE: cfg_next.spike_enable = cfg_wdata[0];
                CFG_EDGE_SKIP:    cfg_next.edge_skip    = cfg_wdata[SKIP_W-1:0];
                CFG_SPIKE_FACTOR: cfg_next.spike_factor = cfg_wdata[FACTOR_W-1:0];
                CFG_SCAN_LENGTH:  cfg_next.scan_length  = cfg_wdata[SLEN_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gate_enable  <= 1'b1;
            cfg_reg.range_min    <= 16'd10;
            cfg_reg.range_max    <= 16'd30000;
            cfg_reg.spike_enable <= 1'b1;
            cfg_reg.edge_skip    <= 8'd1;
            cfg_reg.spike_factor <= 12'd307;
            cfg_reg.scan_length  <= 13'd1081;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // room for two results keeps a scan end from overflowing the queue
    assign take = st_valid && (q_count <= 2'd1);

    lrgsf_gate u_gate (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_range_mm (s_range_mm),
        .take       (take),
        .st_valid   (st_valid),
        .st_gated   (st_gated)
    );

    lrgsf_spike #(
        .MAX_SCAN (MAX_SCAN)
    ) u_spike (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .fire       (take),
        .g          (st_gated),
        .push       (push),
        .pend_valid (pend_valid)
    );

    lrgsf_outq u_outq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (push),
        .count         (q_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_filtered_mm (m_filtered_mm),
        .m_scan_end    (m_scan_end)
    );

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid && !take |=> st_valid && $stable(st_gated))
        else $error("gate register lost a stalled item");

    a_scan_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        push.cnt == 2'd2 |=> !pend_valid)
        else $error("scan end did not restart the scan");

    a_no_push_unprimed: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !pend_valid |-> push.cnt == 2'd0)
        else $error("first item of a scan produced a result");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count == 2'd3 |-> push.cnt == 2'd0)
        else $error("result queue overflow");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for lidar_range_gate_spike_filter: an in-bench predictor
// of the gate and spike stages, random idling on both channels. Depends on lrgsf_pkg.
`timescale 1ns / 100ps

module testbench;
    import lrgsf_pkg::*;

    localparam int MAX_SCAN = 4096;

    typedef struct {
        logic [CFG_AW-1:0] idx;
        logic [CFG_DW-1:0] data;
    } reg_write_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [RANGE_W-1:0]  s_range_mm = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [RANGE_W-1:0]  m_filtered_mm;
    logic                m_scan_end;
    logic                cfg_we = 1'b0;
    logic [CFG_AW-1:0]   cfg_index = '0;
    logic [CFG_DW-1:0]   cfg_wdata = '0;

    // register copy, reset values
    logic                gate_on = 1'b1;
    logic [RANGE_W-1:0]  win_lo = 16'd10;
    logic [RANGE_W-1:0]  win_hi = 16'd30000;
    logic                spike_on = 1'b1;
    logic [SKIP_W-1:0]   skip_n = 8'd1;
    logic [FACTOR_W-1:0] factor = 12'd307;
    logic [SLEN_W-1:0]   len_cfg = 13'd1081;

    // filter state
    logic [RANGE_W-1:0]  prev_filtered = NO_RETURN;
    logic [RANGE_W-1:0]  held_range = NO_RETURN;
    bit                  held_valid = 1'b0;
    int                  scan_count = 0;

    logic [RANGE_W-1:0]  range_feed[$];
    item_t               due_ranges[$];
    reg_write_t          reg_writes[$];
    item_t               want;

    bit                  s_took = 1'b0;
    int                  send_gap = 0;
    int                  recv_gap = 0;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  errors = 0;

    lidar_range_gate_spike_filter #(
        .MAX_SCAN(MAX_SCAN)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_range_mm(s_range_mm),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_filtered_mm(m_filtered_mm),
        .m_scan_end(m_scan_end),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int clamp_len(int l);
        if (l < 2) return 2;
        if (l > MAX_SCAN) return MAX_SCAN;
        return l;
    endfunction

    function automatic logic [RANGE_W-1:0] gate_range(logic [RANGE_W-1:0] x);
        if (gate_on && (x > win_hi || x < win_lo)) return NO_RETURN;
        return x;
    endfunction

    // v scaled by the Q4.8 factor lies strictly below neighbor n; no-return is infinite
    function automatic bit closer_than(logic [RANGE_W-1:0] v, logic [RANGE_W-1:0] n);
        if (n == NO_RETURN) return 1'b1;
        return (32'(v) * 32'(factor)) < (32'(n) << 8);
    endfunction

    function automatic void filter_sample(logic [RANGE_W-1:0] raw);
        logic [RANGE_W-1:0] g;
        logic [RANGE_W-1:0] v;
        int len;
        int skip;
        int p;
        g = gate_range(raw);
        len = clamp_len(int'(len_cfg));
        skip = (skip_n == 0) ? 1 : int'(skip_n);
        if (!held_valid) begin
            held_range = g;
            held_valid = 1'b1;
            scan_count = 1;
            return;
        end
        p = scan_count - 1;
        v = held_range;
        if (spike_on && v != NO_RETURN && p >= skip && p + skip < len &&
            closer_than(v, prev_filtered) && closer_than(v, g))
            v = NO_RETURN;
        due_ranges.push_back('{mm: v, last: 1'b0});
        prev_filtered = v;
        if (scan_count + 1 >= len) begin
            // right neighbor is the last sample of the scan: flush it too
            due_ranges.push_back('{mm: g, last: 1'b1});
            prev_filtered = NO_RETURN;
            held_range = NO_RETURN;
            held_valid = 1'b0;
            scan_count = 0;
        end else begin
            held_range = g;
            scan_count++;
        end
    endfunction

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_took) begin
            // item still waiting for s_ready
        end else if (send_gap > 0) begin
            s_valid <= 1'b0;
            send_gap = send_gap - 1;
        end else if (range_feed.size() != 0 && send_idle_pct != 0 &&
                     $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            send_gap = $urandom_range(0, 11);
        end else if (range_feed.size() != 0) begin
            s_valid <= 1'b1;
            s_range_mm <= range_feed.pop_front();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver backpressure
    always @(negedge aclk) begin
        if (recv_gap > 0) begin
            m_ready <= 1'b0;
            recv_gap = recv_gap - 1;
        end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            m_ready <= 1'b0;
            recv_gap = $urandom_range(0, 11);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: register copy, prediction on accepted items, result checks
    always @(posedge aclk) begin
        s_took <= s_valid && s_ready;
        if (aresetn) begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_GATE_ENABLE:  gate_on = cfg_wdata[0];
                    CFG_RANGE_MIN:    win_lo = cfg_wdata[RANGE_W-1:0];
                    CFG_RANGE_MAX:    win_hi = cfg_wdata[RANGE_W-1:0];
                    CFG_SPIKE_ENABLE: spike_on = cfg_wdata[0];
                    CFG_EDGE_SKIP:    skip_n = cfg_wdata[SKIP_W-1:0];
                    CFG_SPIKE_FACTOR: factor = cfg_wdata[FACTOR_W-1:0];
                    CFG_SCAN_LENGTH:  len_cfg = cfg_wdata[SLEN_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                filter_sample(s_range_mm);
            if (m_valid && m_ready) begin
                if (due_ranges.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected: filtered_mm %0d scan_end %0b",
                             $time, m_filtered_mm, m_scan_end);
                end else begin
                    want = due_ranges.pop_front();
                    if (m_filtered_mm !== want.mm) begin
                        errors++;
                        $display("%0t: filtered_mm expected %0d actual %0d",
                                 $time, want.mm, m_filtered_mm);
                    end
                    if (m_scan_end !== want.last) begin
                        errors++;
                        $display("%0t: scan_end expected %0b actual %0b",
                                 $time, want.last, m_scan_end);
                    end
                end
            end
        end
    end

    // wait until every item is taken and every result is back, then let
    // a first-of-scan item (no result) clear the pipeline
    task automatic drain();
        while (range_feed.size() != 0 || s_valid || due_ranges.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic push_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
        reg_writes.push_back('{idx: idx, data: data});
    endtask

    task automatic apply_regs();
        drain();
        while (reg_writes.size() != 0) begin
            @(negedge aclk);
            cfg_we <= 1'b1;
            cfg_index <= reg_writes[0].idx;
            cfg_wdata <= reg_writes[0].data;
            void'(reg_writes.pop_front());
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [RANGE_W-1:0] pick_range(int base);
        case ($urandom_range(0, 11))
            0: return RANGE_W'($urandom);
            1: return NO_RETURN;
            2: return RANGE_W'(base / $urandom_range(2, 6));
            3: return RANGE_W'($urandom_range(0, 20));
            default: return RANGE_W'(base + $urandom_range(0, 200) - 100);
        endcase
    endfunction

    function automatic int pick_idle();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 35;
        endcase
    endfunction

    initial begin
        #(20_000_000);
        $display("lidar_range_gate_spike_filter regression: fail");
        $finish;
    end

    initial begin
        int n;
        int base;
        int cur_len;
        int val;
        int phase;
        int rand_items;
        bit all_regs;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: window edges, no-return, near-max values
        send_idle_pct = 20;
        recv_idle_pct = 20;
        range_feed = '{16'd0, 16'd9, 16'd10, 16'd30000, 16'd30001, 16'd65534,
                       NO_RETURN, 16'd1000};

        // oversized length clamps; then shrinking it ends the scan in progress
        push_reg(CFG_SCAN_LENGTH, 16'd8191);
        apply_regs();
        range_feed = '{16'd1200, 16'd1100};
        push_reg(CFG_SCAN_LENGTH, 16'd5);
        apply_regs();
        range_feed = '{16'd900};

        // length zero acts as two
        push_reg(CFG_SCAN_LENGTH, 16'd0);
        apply_regs();
        range_feed = '{16'd700, 16'd650};

        // spikes with gating off and a skip count of zero
        push_reg(CFG_GATE_ENABLE, 16'd0);
        push_reg(CFG_EDGE_SKIP, 16'd0);
        push_reg(CFG_SPIKE_ENABLE, 16'd1);
        push_reg(CFG_SCAN_LENGTH, 16'd7);
        apply_regs();
        range_feed = '{16'd2000, 16'd2000, 16'd500, 16'd2000, NO_RETURN, 16'd0, 16'd2000};
        cur_len = 7;

        phase = 0;
        rand_items = 0;
        while (rand_items < 1500) begin
            all_regs = (phase == 0);
            if (all_regs || $urandom_range(0, 1))
                push_reg(CFG_GATE_ENABLE, CFG_DW'($urandom_range(0, 1)));
            if (all_regs || $urandom_range(0, 1)) begin
                case ($urandom_range(0, 7))
                    0: val = 0;
                    1: val = 65534;
                    default: val = $urandom_range(0, 500);
                endcase
                push_reg(CFG_RANGE_MIN, CFG_DW'(val));
            end
            if (all_regs || $urandom_range(0, 1)) begin
                case ($urandom_range(0, 7))
                    0: val = 0;
                    1: val = 65534;
                    default: val = $urandom_range(15000, 65534);
                endcase
                push_reg(CFG_RANGE_MAX, CFG_DW'(val));
            end
            if (all_regs || $urandom_range(0, 1))
                push_reg(CFG_SPIKE_ENABLE, CFG_DW'($urandom_range(0, 3) != 0));
            if (all_regs || $urandom_range(0, 1)) begin
                case ($urandom_range(0, 9))
                    0: val = 255;
                    1: val = $urandom_range(1, 255);
                    default: val = $urandom_range(1, 4);
                endcase
                push_reg(CFG_EDGE_SKIP, CFG_DW'(val));
            end
            if (all_regs || $urandom_range(0, 1)) begin
                case ($urandom_range(0, 5))
                    0: val = 0;
                    1: val = 4095;
                    2: val = 307;
                    default: val = $urandom_range(0, 4095);
                endcase
                push_reg(CFG_SPIKE_FACTOR, CFG_DW'(val));
            end

            if (phase == 2) begin
                // long scan so the widest skip still leaves samples to test
                push_reg(CFG_EDGE_SKIP, 16'd255);
                push_reg(CFG_SPIKE_ENABLE, 16'd1);
                push_reg(CFG_SCAN_LENGTH, 16'd600);
                cur_len = 600;
                n = 600;
            end else if (phase % 15 == 7) begin
                // largest lengths: only a partial scan, the next phase shortens it
                val = $urandom_range(0, 1) ? MAX_SCAN : 8191;
                push_reg(CFG_SCAN_LENGTH, CFG_DW'(val));
                cur_len = clamp_len(val);
                n = $urandom_range(5, 40);
            end else begin
                if (all_regs || cur_len >= 600 || $urandom_range(0, 1)) begin
                    case ($urandom_range(0, 19))
                        0: val = $urandom_range(0, 1);
                        1: val = 2;
                        default: val = $urandom_range(3, 40);
                    endcase
                    push_reg(CFG_SCAN_LENGTH, CFG_DW'(val));
                    cur_len = clamp_len(val);
                end
                n = cur_len * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0)
                    n += $urandom_range(1, cur_len - 1);
            end
            apply_regs();

            if (rand_items > 1300) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = pick_idle();
                recv_idle_pct = pick_idle();
            end
            base = $urandom_range(300, 20000);
            repeat (n) range_feed.push_back(pick_range(base));
            rand_items += n;
            phase++;
        end

        drain();
        repeat (20) @(posedge aclk);
        if (errors == 0 && due_ranges.size() == 0)
            $display("lidar_range_gate_spike_filter regression: pass");
        else
            $display("lidar_range_gate_spike_filter regression: fail");
        $finish;
    end

endmodule
